/* sv/hfcr_pkg.sv */
// ----------------------------------------------------------------------------
// hfcr_pkg: shared types and constants
// Byte codes, reset values and the op word passed from front to back end.
// ----------------------------------------------------------------------------
package hfcr_pkg;

  localparam int unsigned RING_DEPTH  = 64;

  localparam logic [7:0]  HDR_BYTE    = 8'd255;
  localparam logic [7:0]  ECHO_REQ    = 8'd13;
  localparam int unsigned LEVEL_SHIFT = 8;

  localparam logic [7:0]  CMD_MODE_A  = 8'd1;
  localparam logic [7:0]  CMD_MODE_B  = 8'd2;
  localparam logic [7:0]  CMD_MODE_C  = 8'd4;

  localparam logic [2:0]  MODE_RESET  = 3'd1;
  localparam logic [15:0] LEVEL_RESET = 16'hFFFF;

  // classified byte: store or pop, and whether it closes a packet
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       is_echo;
    logic       do_decode;
  } hfcr_op_t;

endpackage

/* sv/hfcr_if.sv */
// ----------------------------------------------------------------------------
// hfcr_if: channel interfaces
// Received-byte channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hfcr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hfcr_res_if;
  logic        valid;
  logic        ready;
  logic        echo_valid;
  logic [7:0]  echo_byte;
  logic        ack_valid;
  logic [7:0]  ack_byte;
  logic [2:0]  mode;
  logic [15:0] level;

  modport source (output valid, output echo_valid, output echo_byte,
                  output ack_valid, output ack_byte, output mode, output level,
                  input ready);
  modport sink   (input valid, input echo_valid, input echo_byte,
                  input ack_valid, input ack_byte, input mode, input level,
                  output ready);
endinterface

/* sv/hfcr_front.sv */
// ----------------------------------------------------------------------------
// hfcr_front: byte classifier
// Accepts received bytes, tracks the packet byte count, emits op words.
// ----------------------------------------------------------------------------
module hfcr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  hfcr_rx_if.sink           rx_i,
  output logic              op_valid_o,
  input  logic              op_ready_i,
  output hfcr_pkg::hfcr_op_t op_o
);

  logic [1:0] pkt_cnt_q, pkt_cnt_d;
  logic [1:0] cnt_next;
  logic       accept;

  assign rx_i.ready = op_ready_i;
  assign op_valid_o = rx_i.valid;
  assign accept     = rx_i.valid & op_ready_i;

  // header restarts the count at one; third byte triggers a decode
  always_comb begin
    if (rx_i.rx_byte == hfcr_pkg::HDR_BYTE) begin
      cnt_next = 2'd1;
    end else begin
      cnt_next = pkt_cnt_q + 2'd1;
    end
    op_o.rx_byte   = rx_i.rx_byte;
    op_o.is_echo   = (rx_i.rx_byte == hfcr_pkg::ECHO_REQ);
    op_o.do_decode = (cnt_next == 2'd3);
    pkt_cnt_d      = op_o.do_decode ? 2'd0 : cnt_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_cnt_q <= 2'd0;
    end else if (accept) begin
      pkt_cnt_q <= pkt_cnt_d;
    end
  end

endmodule

/* sv/hfcr_queue.sv */
// ----------------------------------------------------------------------------
// hfcr_queue: two-entry op queue
// Decouples the classifier from the execution engine.
// ----------------------------------------------------------------------------
module hfcr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  hfcr_pkg::hfcr_op_t push_op_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output hfcr_pkg::hfcr_op_t pop_op_o
);

  hfcr_pkg::hfcr_op_t slot_q [2];
  logic       wr_idx_q, rd_idx_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_op_o     = slot_q[rd_idx_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_idx_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= 1'b0;
      rd_idx_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_idx_q <= ~wr_idx_q;
      end
      if (do_pop) begin
        rd_idx_q <= ~rd_idx_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* sv/hfcr_back.sv */
// ----------------------------------------------------------------------------
// hfcr_back: execution engine
// Owns the ring, pointers, mode and level; runs pops and header searches.
// ----------------------------------------------------------------------------
module hfcr_back #(
  parameter int unsigned RingDepth = hfcr_pkg::RING_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               op_valid_i,
  output logic               op_ready_o,
  input  hfcr_pkg::hfcr_op_t op_i,
  hfcr_res_if.source         res_o
);

  localparam int unsigned PtrW = $clog2(RingDepth);

  typedef enum logic [2:0] {
    S_IDLE, S_ECHO, S_SRD, S_SCHK, S_CMD, S_DAT, S_OUT
  } state_e;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(RingDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  state_e state_q;

  logic [7:0]           ring_mem [RingDepth];
  logic [RingDepth-1:0] ring_vld_q;
  logic [7:0]           rd_raw_q;
  logic                 rd_vld_q;
  logic [7:0]           rd_data;
  logic [PtrW-1:0]      rd_addr;
  logic                 wr_en;

  logic [PtrW-1:0] wp_q, rp_q, p_q, steps_q;
  logic            decode_q;
  logic            echo_v_q, ack_v_q;
  logic [7:0]      echo_b_q, ack_b_q;
  logic [2:0]      mode_q;
  logic [15:0]     level_q;

  logic            out_valid_q;
  logic            out_echo_v_q, out_ack_v_q;
  logic [7:0]      out_echo_b_q, out_ack_b_q;
  logic [2:0]      out_mode_q;
  logic [15:0]     out_level_q;

  logic            take;

  assign op_ready_o = (state_q == S_IDLE);
  assign take       = op_valid_i & op_ready_o;
  assign wr_en      = take & ~op_i.is_echo;

  // entries never written since reset read as zero
  assign rd_data = rd_vld_q ? rd_raw_q : 8'd0;

  always_comb begin
    case (state_q)
      S_IDLE:  rd_addr = rp_q;
      S_SRD:   rd_addr = rp_q;
      S_SCHK:  rd_addr = ptr_inc(p_q);
      S_CMD:   rd_addr = ptr_inc(p_q);
      default: rd_addr = p_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wp_q] <= op_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_raw_q <= ring_mem[rd_addr];
    rd_vld_q <= ring_vld_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ring_vld_q   <= '0;
      wp_q         <= '0;
      rp_q         <= '0;
      p_q          <= '0;
      steps_q      <= '0;
      decode_q     <= 1'b0;
      echo_v_q     <= 1'b0;
      echo_b_q     <= 8'd0;
      ack_v_q      <= 1'b0;
      ack_b_q      <= 8'd0;
      mode_q       <= hfcr_pkg::MODE_RESET;
      level_q      <= hfcr_pkg::LEVEL_RESET;
      out_valid_q  <= 1'b0;
      out_echo_v_q <= 1'b0;
      out_echo_b_q <= 8'd0;
      out_ack_v_q  <= 1'b0;
      out_ack_b_q  <= 8'd0;
      out_mode_q   <= hfcr_pkg::MODE_RESET;
      out_level_q  <= hfcr_pkg::LEVEL_RESET;
    end else begin
      // S_OUT reloads the output word itself when it is taken
      if (out_valid_q && res_o.ready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (take) begin
            decode_q <= op_i.do_decode;
            echo_v_q <= 1'b0;
            echo_b_q <= 8'd0;
            ack_v_q  <= 1'b0;
            ack_b_q  <= 8'd0;
            if (!op_i.is_echo) begin
              ring_vld_q[wp_q] <= 1'b1;
              wp_q             <= ptr_inc(wp_q);
              state_q          <= op_i.do_decode ? S_SRD : S_OUT;
            end else if (rp_q != wp_q) begin
              state_q <= S_ECHO;
            end else begin
              state_q <= op_i.do_decode ? S_SRD : S_OUT;
            end
          end
        end
        S_ECHO: begin
          echo_v_q <= 1'b1;
          echo_b_q <= rd_data;
          rp_q     <= ptr_inc(rp_q);
          state_q  <= decode_q ? S_SRD : S_OUT;
        end
        S_SRD: begin
          p_q     <= rp_q;
          steps_q <= '0;
          state_q <= S_SCHK;
        end
        S_SCHK: begin
          // one entry checked per cycle, next read already in flight
          p_q <= ptr_inc(p_q);
          if (rd_data == hfcr_pkg::HDR_BYTE) begin
            state_q <= S_CMD;
          end else if (steps_q == PtrW'(RingDepth - 1)) begin
            state_q <= S_OUT;
          end else begin
            steps_q <= steps_q + PtrW'(1);
          end
        end
        S_CMD: begin
          ack_b_q <= rd_data;
          p_q     <= ptr_inc(p_q);
          state_q <= S_DAT;
        end
        S_DAT: begin
          rp_q    <= ptr_inc(p_q);
          level_q <= {rd_data, 8'd0} << (hfcr_pkg::LEVEL_SHIFT - 8);
          if (ack_b_q inside {hfcr_pkg::CMD_MODE_A, hfcr_pkg::CMD_MODE_B,
                              hfcr_pkg::CMD_MODE_C}) begin
            ack_v_q <= 1'b1;
            mode_q  <= ack_b_q[2:0];
          end else begin
            ack_b_q <= 8'd0;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || res_o.ready) begin
            out_valid_q  <= 1'b1;
            out_echo_v_q <= echo_v_q;
            out_echo_b_q <= echo_b_q;
            out_ack_v_q  <= ack_v_q;
            out_ack_b_q  <= ack_b_q;
            out_mode_q   <= mode_q;
            out_level_q  <= level_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.echo_valid = out_echo_v_q;
  assign res_o.echo_byte  = out_echo_b_q;
  assign res_o.ack_valid  = out_ack_v_q;
  assign res_o.ack_byte   = out_ack_b_q;
  assign res_o.mode       = out_mode_q;
  assign res_o.level      = out_level_q;

endmodule

/* sv/header_framed_command_receiver.sv */
// ----------------------------------------------------------------------------
// header_framed_command_receiver: byte-stream command receiver
// Stores received bytes in a ring, echoes on request, decodes header packets.
// ----------------------------------------------------------------------------
// One result word per received byte. A stored byte is written to the ring,
// an echo request reads the oldest entry back when there is one; a byte that
// ends a packet adds a header search through the ring at one entry per cycle
// (at most RingDepth entries), with setup, command and data read steps.
// The search walks through the single ring read port. A two-word queue in
// front of the engine keeps taking bytes while the engine works, as long
// as it has room, and an output register holds the finished result. The
// ring reads as all zeros after reset through per-entry valid bits; no
// clearing pass is needed.
module header_framed_command_receiver #(
  parameter int unsigned RingDepth = hfcr_pkg::RING_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hfcr_rx_if.sink    rx_i,
  hfcr_res_if.source res_o
);

  // front to queue
  logic               fq_valid, fq_ready;
  hfcr_pkg::hfcr_op_t fq_op;
  // queue to engine
  logic               qb_valid, qb_ready;
  hfcr_pkg::hfcr_op_t qb_op;

  // classifier: packet byte count, echo/store decision
  hfcr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_i),
    .op_valid_o (fq_valid),
    .op_ready_i (fq_ready),
    .op_o       (fq_op)
  );

  hfcr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_op_i    (fq_op),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_op_o     (qb_op)
  );

  // engine: ring, pointers, header search, mode and level
  hfcr_back #(
    .RingDepth (RingDepth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (qb_valid),
    .op_ready_o (qb_ready),
    .op_i       (qb_op),
    .res_o      (res_o)
  );

endmodule
